FILE: hdl/bbcm_pkg.sv
// ----------------------------------------------------------------------------
// Block buffer cache manager package
// Shared opcode and status codes, the queue entry type and the response type.
// ----------------------------------------------------------------------------
`default_nettype none
package bbcm_pkg;
    typedef enum logic [2:0] {
        OP_GET = 3'd0, OP_RELEASE = 3'd1, OP_DIRTY = 3'd2,
        OP_WRITEBACK = 3'd3, OP_WB_RELEASE = 3'd4
    } opcode_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_NO_FREE  = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] device;
        logic [31:0] block_number;
        logic [7:0]  slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_slot;
        logic        slot_dirty;
        logic        read_request;
        logic        writeback_request;
        logic [15:0] writeback_device;
        logic [31:0] writeback_block;
    } rsp_t;
endpackage
`default_nettype wire

FILE: hdl/bbcm_front.sv
// ----------------------------------------------------------------------------
// Block buffer cache manager front end
// Accepts words, drops undefined opcodes and queues commands (two entries).
// ----------------------------------------------------------------------------
`default_nettype none
module bbcm_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bbcm_pkg::cmd_t in_cmd,
    output logic                q_valid,
    input  wire logic           q_take,
    output bbcm_pkg::cmd_t      q_cmd
);
    import bbcm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_cmd.opcode <= OP_WB_RELEASE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_take) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_take};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/bbcm_back.sv
// ----------------------------------------------------------------------------
// Block buffer cache manager back end
// Holds the slot tags and flags and executes one command at a time:
// a lookup state that registers hit and victim, then an update state.
// ----------------------------------------------------------------------------
`default_nettype none
module bbcm_back #(
    parameter int NUM_BUFFERS = 16,
    parameter int COUNT_BITS  = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_take,
    input  wire bbcm_pkg::cmd_t q_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bbcm_pkg::rsp_t      out_rsp
);
    import bbcm_pkg::*;

    localparam int SW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC} state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [15:0]         tdev_reg [NUM_BUFFERS];
    logic [31:0]         tblk_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] valid_reg, dirty_reg, used_reg;
    logic [COUNT_BITS-1:0] cnt_reg [NUM_BUFFERS];
    logic [SW-1:0]       scan_reg;
    logic                hit_reg, found_reg;
    logic [SW-1:0]       hslot_reg, vslot_reg;
    logic                out_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    // Slot index base + k, wrapped into 0..NUM_BUFFERS-1 (both below N).
    function automatic logic [SW-1:0] scan_pos(input logic [SW-1:0] base, input int k);
        logic [SW:0] sum;
        sum = {1'b0, base} + (SW+1)'(k);
        if (sum >= (SW+1)'(NUM_BUFFERS)) sum = sum - (SW+1)'(NUM_BUFFERS);
        return sum[SW-1:0];
    endfunction

    // lookup logic
    logic          hit_c, clean_f, dirty_f;
    logic [SW-1:0] hslot_c, clean_s, dirty_s, pos;

    always_comb begin
        hit_c = 1'b0; hslot_c = '0;
        clean_f = 1'b0; clean_s = '0; dirty_f = 1'b0; dirty_s = '0;
        pos = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (valid_reg[i] && tdev_reg[i] == cmd_reg.device
                    && tblk_reg[i] == cmd_reg.block_number) begin
                hit_c = 1'b1; hslot_c = SW'(i);
            end
        end
        // scan order: offsets 0..N-1 from scan_reg; first clean, last dirty
        for (int k = NUM_BUFFERS - 1; k >= 0; k--) begin
            pos = scan_pos(scan_reg, k);
            if (!used_reg[pos] && !dirty_reg[pos]) begin
                clean_f = 1'b1; clean_s = pos;
            end
        end
        for (int k = 0; k < NUM_BUFFERS; k++) begin
            pos = scan_pos(scan_reg, k);
            if (!used_reg[pos] && dirty_reg[pos]) begin
                dirty_f = 1'b1; dirty_s = pos;
            end
        end
    end

    logic in_rng;
    logic [SW-1:0] as;
    assign in_rng = (32'(cmd_reg.slot) < NUM_BUFFERS);
    assign as     = cmd_reg.slot[SW-1:0];
    assign q_take = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;

    // Response word of the command in the update cycle.
    always_comb begin
        rsp_next = '0;
        if (cmd_reg.opcode == OP_GET) begin
            if (hit_reg) begin
                rsp_next.result_slot = 8'(hslot_reg);
                rsp_next.slot_dirty  = dirty_reg[hslot_reg];
            end else if (!found_reg) begin
                rsp_next.status = ST_NO_FREE;
            end else begin
                if (dirty_reg[vslot_reg]) begin
                    rsp_next.writeback_request = 1'b1;
                    rsp_next.writeback_device  = tdev_reg[vslot_reg];
                    rsp_next.writeback_block   = tblk_reg[vslot_reg];
                end
                rsp_next.read_request = 1'b1;
                rsp_next.result_slot  = 8'(vslot_reg);
            end
        end else begin
            rsp_next.result_slot = cmd_reg.slot;
            if (!in_rng) begin
                rsp_next.status = ST_RANGE;
            end else if (cmd_reg.opcode == OP_DIRTY) begin
                rsp_next.slot_dirty = 1'b1;
            end else if (cnt_reg[as] == '0) begin
                rsp_next.status     = ST_NOT_HELD;
                rsp_next.slot_dirty = dirty_reg[as];
            end else if (cmd_reg.opcode != OP_RELEASE && valid_reg[as] && dirty_reg[as]) begin
                rsp_next.writeback_request = 1'b1;
                rsp_next.writeback_device  = tdev_reg[as];
                rsp_next.writeback_block   = tblk_reg[as];
                rsp_next.slot_dirty        = 1'b0;
            end else begin
                rsp_next.slot_dirty = dirty_reg[as];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0; dirty_reg <= '0; used_reg <= '0;
            scan_reg <= '0; out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                tdev_reg[i] <= '0; tblk_reg[i] <= '0; cnt_reg[i] <= '0;
            end
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_take) begin
                        cmd_reg <= q_cmd;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    hit_reg   <= hit_c;
                    hslot_reg <= hslot_c;
                    found_reg <= clean_f || dirty_f;
                    vslot_reg <= clean_f ? clean_s : dirty_s;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b1;
                    rsp_reg <= rsp_next;
                    if (cmd_reg.opcode == OP_GET) begin
                        if (hit_reg) begin
                            if (cnt_reg[hslot_reg] != CMAX)
                                cnt_reg[hslot_reg] <= cnt_reg[hslot_reg] + 1'b1;
                            used_reg[hslot_reg] <= 1'b1;
                        end else begin
                            scan_reg <= scan_pos(scan_reg, 1);
                            if (found_reg) begin
                                if (dirty_reg[vslot_reg]) begin
                                    dirty_reg[vslot_reg] <= 1'b0;
                                end
                                tdev_reg[vslot_reg] <= cmd_reg.device;
                                tblk_reg[vslot_reg] <= cmd_reg.block_number;
                                valid_reg[vslot_reg] <= 1'b1;
                                used_reg[vslot_reg] <= 1'b1;
                                if (cnt_reg[vslot_reg] != CMAX)
                                    cnt_reg[vslot_reg] <= cnt_reg[vslot_reg] + 1'b1;
                            end
                        end
                    end else begin
                        if (!in_rng) begin
                            // Out of range: no state change.
                        end else if (cmd_reg.opcode == OP_DIRTY) begin
                            dirty_reg[as] <= 1'b1;
                        end else if (cnt_reg[as] != '0) begin
                            if (cmd_reg.opcode != OP_RELEASE && valid_reg[as]
                                    && dirty_reg[as]) begin
                                dirty_reg[as] <= 1'b0;
                            end
                            if (cmd_reg.opcode == OP_RELEASE
                                    || cmd_reg.opcode == OP_WB_RELEASE) begin
                                cnt_reg[as] <= cnt_reg[as] - 1'b1;
                                if (cnt_reg[as] == COUNT_BITS'(1)) used_reg[as] <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/block_buffer_cache_manager_unit.sv
// ----------------------------------------------------------------------------
// Block buffer cache manager
// Tag and flag manager for a fixed set of block buffers.
// ----------------------------------------------------------------------------
// A word passes through the queue, the lookup and the update before it reaches
// m_. The back end takes a new command only once the result of the last one
// has been handed off, after its take, lookup and update sequence. Reset
// (aresetn low, synchronous) clears all tags, flags, counts, the scan origin
// and the command queue; no clearing pass.
`default_nettype none
module block_buffer_cache_manager_unit #(
    parameter int NUM_BUFFERS = 16,
    parameter int COUNT_BITS  = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[2:0], device[18:3], block_number[50:19], slot[58:51], zeros
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], result_slot[9:2], slot_dirty[10], read_request[11],
    // writeback_request[12], writeback_device[28:13],
    // writeback_block[60:29], zeros
    output logic [63:0]      m_tdata
);
    import bbcm_pkg::*;

    cmd_t in_cmd, q_cmd;
    rsp_t rsp;
    logic q_valid, q_take;

    // Unpack the incoming word into the command fields.
    assign in_cmd.opcode       = s_tdata[2:0];
    assign in_cmd.device       = s_tdata[18:3];
    assign in_cmd.block_number = s_tdata[50:19];
    assign in_cmd.slot         = s_tdata[58:51];

    // The front end queues commands so acceptance continues while the back
    // end works or its result waits.
    bbcm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    bbcm_back #(.NUM_BUFFERS(NUM_BUFFERS), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rsp(rsp)
    );

    // Pack the result word, low field first.
    assign m_tdata = {3'b000, rsp.writeback_block, rsp.writeback_device,
                      rsp.writeback_request, rsp.read_request, rsp.slot_dirty,
                      rsp.result_slot, rsp.status};

    // A read request always comes with an ok status.
    a_rd_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[1:0] == ST_OK)
        else $error("read request with bad status");
    // A non-ok result never carries a write back.
    a_wb_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[1:0] == ST_OK)
        else $error("write back with bad status");
    // The result holds while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: dv/block_buffer_cache_manager_unit_tb.sv
// ----------------------------------------------------------------------------
// Block buffer cache manager testbench
// Drives get, release, mark dirty and write back commands into the cache
// manager and checks every response against a behavioral tag and flag model.
// ----------------------------------------------------------------------------
`default_nettype none

class buffer_tag_tracker;
    localparam int NBUF = 16;
    localparam int CMAX = 255;

    logic [15:0] tag_dev   [NBUF];
    logic [31:0] tag_blk   [NBUF];
    bit          valid     [NBUF];
    bit          dirty     [NBUF];
    bit          in_use    [NBUF];
    int          refs      [NBUF];
    int          scan_origin;
    bbcm_pkg::rsp_t pending_rsp[$];
    int          errors;
    int          checked;
    int          misses;
    int          writebacks;

    function new();
        for (int i = 0; i < NBUF; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            valid[i] = 0;
            dirty[i] = 0;
            in_use[i] = 0;
            refs[i] = 0;
        end
        scan_origin = 0;
        errors = 0;
        checked = 0;
        misses = 0;
        writebacks = 0;
    endfunction

    function void take_ref(int s);
        if (refs[s] < CMAX) refs[s]++;
        in_use[s] = 1;
    endfunction

    // Apply one accepted command to the tag model and queue its response.
    function void note_command(bbcm_pkg::cmd_t c);
        bbcm_pkg::rsp_t r;
        bit hit;
        bit found;
        int s;
        int pos;
        hit = 0;
        found = 0;
        s = 0;
        r = '0;
        if (c.opcode > 3'd4) return;
        if (c.opcode == bbcm_pkg::OP_GET) begin
            for (int i = 0; i < NBUF; i++) begin
                if (!hit && valid[i] && tag_dev[i] == c.device && tag_blk[i] == c.block_number) begin
                    hit = 1;
                    s = i;
                end
            end
            if (hit) begin
                take_ref(s);
                r.result_slot = 8'(s);
                r.slot_dirty = dirty[s];
            end else begin
                misses++;
                pos = scan_origin;
                for (int i = 0; i < NBUF; i++) begin
                    if (!(found && !dirty[s]) && !in_use[pos]) begin
                        s = pos;
                        found = 1;
                    end
                    pos = (pos + 1) % NBUF;
                end
                scan_origin = (scan_origin + 1) % NBUF;
                if (!found) begin
                    r.status = bbcm_pkg::ST_NO_FREE;
                end else begin
                    if (dirty[s]) begin
                        r.writeback_request = 1;
                        r.writeback_device = tag_dev[s];
                        r.writeback_block = tag_blk[s];
                        dirty[s] = 0;
                    end
                    tag_dev[s] = c.device;
                    tag_blk[s] = c.block_number;
                    valid[s] = 1;
                    take_ref(s);
                    r.read_request = 1;
                    r.result_slot = 8'(s);
                end
            end
        end else begin
            r.result_slot = c.slot;
            s = c.slot;
            if (c.slot >= NBUF) begin
                r.status = bbcm_pkg::ST_RANGE;
            end else if (c.opcode == bbcm_pkg::OP_DIRTY) begin
                dirty[s] = 1;
                r.slot_dirty = 1;
            end else if (refs[s] == 0) begin
                r.status = bbcm_pkg::ST_NOT_HELD;
                r.slot_dirty = dirty[s];
            end else begin
                if (c.opcode == bbcm_pkg::OP_WRITEBACK || c.opcode == bbcm_pkg::OP_WB_RELEASE) begin
                    if (valid[s] && dirty[s]) begin
                        r.writeback_request = 1;
                        r.writeback_device = tag_dev[s];
                        r.writeback_block = tag_blk[s];
                        dirty[s] = 0;
                    end
                end
                if (c.opcode == bbcm_pkg::OP_RELEASE || c.opcode == bbcm_pkg::OP_WB_RELEASE) begin
                    refs[s]--;
                    if (refs[s] == 0) in_use[s] = 0;
                end
                r.slot_dirty = dirty[s];
            end
        end
        if (r.writeback_request) writebacks++;
        pending_rsp.push_back(r);
    endfunction

    // Compare one response word with the oldest pending expectation.
    function void check_response(bbcm_pkg::rsp_t a);
        bbcm_pkg::rsp_t e;
        checked++;
        if (pending_rsp.size() == 0) begin
            $error("response with no command pending: %h", a);
            errors++;
            return;
        end
        e = pending_rsp.pop_front();
        if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status); errors++;
        end
        if (a.result_slot !== e.result_slot) begin
            $error("result_slot: expected %0d, got %0d", e.result_slot, a.result_slot); errors++;
        end
        if (a.slot_dirty !== e.slot_dirty) begin
            $error("slot_dirty: expected %0d, got %0d", e.slot_dirty, a.slot_dirty); errors++;
        end
        if (a.read_request !== e.read_request) begin
            $error("read_request: expected %0d, got %0d", e.read_request, a.read_request); errors++;
        end
        if (a.writeback_request !== e.writeback_request) begin
            $error("writeback_request: expected %0d, got %0d",
                   e.writeback_request, a.writeback_request); errors++;
        end
        if (a.writeback_device !== e.writeback_device) begin
            $error("writeback_device: expected %h, got %h",
                   e.writeback_device, a.writeback_device); errors++;
        end
        if (a.writeback_block !== e.writeback_block) begin
            $error("writeback_block: expected %h, got %h",
                   e.writeback_block, a.writeback_block); errors++;
        end
    endfunction
endclass

module block_buffer_cache_manager_unit_tb;
    import bbcm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // opcode[2:0], device[18:3], block_number[50:19], slot[58:51], zeros
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // status[1:0], result_slot[9:2], slot_dirty[10], read_request[11],
    // writeback_request[12], writeback_device[28:13],
    // writeback_block[60:29], zeros
    logic [63:0] m_tdata;

    buffer_tag_tracker tracker;
    int  cycle_count = 0;
    // When set, the receiver process takes one long stall so the queue fills.
    bit  hold_request;

    // A small pool of tags keeps hits frequent; the rest is fully random.
    logic [15:0] dev_pool [4];
    logic [31:0] blk_pool [6];

    block_buffer_cache_manager_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one command word and hold it until the handshake completes.
    task automatic send_command(cmd_t c);
        logic [63:0] w;
        w = '0;
        w[58:0] = {c.slot, c.block_number, c.device, c.opcode};
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(c);
    endtask

    task automatic send_idle(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom};
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic cmd_t make_cmd(logic [2:0] op, logic [15:0] d, logic [31:0] b,
                                      logic [7:0] s);
        cmd_t c;
        c.opcode = op;
        c.device = d;
        c.block_number = b;
        c.slot = s;
        return c;
    endfunction

    // Mostly well-formed traffic on a small tag set with slots in range.
    function automatic cmd_t random_cmd();
        int k;
        logic [2:0] op;
        logic [15:0] d;
        logic [31:0] b;
        logic [7:0] s;
        k = $urandom_range(0, 99);
        if (k < 40) op = OP_GET;
        else if (k < 65) op = OP_RELEASE;
        else if (k < 77) op = OP_DIRTY;
        else if (k < 86) op = OP_WRITEBACK;
        else if (k < 95) op = OP_WB_RELEASE;
        else op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) < 8) begin
            d = dev_pool[$urandom_range(0, 3)];
            b = blk_pool[$urandom_range(0, 5)];
        end else begin
            d = 16'($urandom);
            b = $urandom;
        end
        if ($urandom_range(0, 19) == 0) s = 8'($urandom_range(16, 255));
        else s = 8'($urandom_range(0, 15));
        return make_cmd(op, d, b, s);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending_rsp.size() != 0) @(posedge aclk);
    endtask

    // Response side: accept words with random stalls and one long hold-off.
    initial begin
        int n;
        rsp_t got;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_request = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.status            = m_tdata[1:0];
                got.result_slot       = m_tdata[9:2];
                got.slot_dirty        = m_tdata[10];
                got.read_request      = m_tdata[11];
                got.writeback_request = m_tdata[12];
                got.writeback_device  = m_tdata[28:13];
                got.writeback_block   = m_tdata[60:29];
                tracker.check_response(got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int n_random;
        int settle;
        cmd_t c;
        tracker = new();
        hold_request = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        for (int i = 0; i < 4; i++) dev_pool[i] = 16'($urandom);
        for (int i = 0; i < 6; i++) blk_pool[i] = $urandom;
        dev_pool[0] = 16'hFFFF;
        blk_pool[0] = 32'hFFFF_FFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, every opcode, and the corner cases.
        send_command(make_cmd(OP_RELEASE, 16'h0, 32'h0, 8'd3));      // not held
        send_command(make_cmd(OP_WRITEBACK, 16'h0, 32'h0, 8'd0));    // not held
        send_command(make_cmd(OP_DIRTY, 16'h0, 32'h0, 8'd5));        // unheld slot
        send_command(make_cmd(OP_GET, 16'h0, 32'h0, 8'd0));          // miss
        send_command(make_cmd(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(make_cmd(OP_GET, 16'h0, 32'h0, 8'd0));          // hit
        send_command(make_cmd(OP_DIRTY, 16'h0, 32'h0, 8'd0));
        send_command(make_cmd(OP_WRITEBACK, 16'h0, 32'h0, 8'd0));
        send_command(make_cmd(OP_DIRTY, 16'h0, 32'h0, 8'd1));
        send_command(make_cmd(OP_WB_RELEASE, 16'h0, 32'h0, 8'd1));
        send_command(make_cmd(OP_RELEASE, 16'h0, 32'h0, 8'd16));     // out of range
        send_command(make_cmd(OP_DIRTY, 16'h0, 32'h0, 8'hFF));
        send_command(make_cmd(OP_WB_RELEASE, 16'h0, 32'h0, 8'd200));
        send_command(make_cmd(3'd5, 16'h1234, 32'h1, 8'd0));         // ignored
        send_command(make_cmd(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        // Fill every slot so a further miss finds no free buffer.
        for (int i = 0; i < 16; i++)
            send_command(make_cmd(OP_GET, 16'hA5A5, 32'(i + 100), 8'd0));
        send_command(make_cmd(OP_GET, 16'h5A5A, 32'h8000_0000, 8'd0));
        // Saturate the reference count of one slot.
        for (int i = 0; i < 260; i++)
            send_command(make_cmd(OP_GET, 16'hA5A5, 32'd100, 8'd0));
        wait_drained();
        // Release everything so the random part starts from free slots.
        for (int i = 0; i < 16; i++)
            while (tracker.refs[i] > 0)
                send_command(make_cmd(OP_RELEASE, 16'h0, 32'h0, 8'(i)));

        // Random part, with one long receiver hold-off and one full drain.
        n_random = 0;
        while (n_random < 220) begin
            c = random_cmd();
            send_command(c);
            if (c.opcode <= 3'd4) n_random++;
            if (n_random == 60) hold_request = 1;
            if (n_random == 140) wait_drained();
            if ($urandom_range(0, 2) == 0) send_idle(gap_length());
            // Keep the pool from locking up forever under held references.
            if ($urandom_range(0, 29) == 0)
                for (int i = 0; i < 16; i++)
                    if (tracker.refs[i] > 0 && tracker.refs[i] < 8)
                        send_command(make_cmd(OP_RELEASE, 16'h0, 32'h0, 8'(i)));
        end
        s_tvalid <= 1'b0;

        while (tracker.pending_rsp.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < 20) begin
            @(posedge aclk);
            settle++;
        end
        $display("checked %0d responses: %0d misses, %0d write back requests",
                 tracker.checked, tracker.misses, tracker.writebacks);
        if (tracker.errors == 0 && tracker.pending_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
